@@ hdl/debounced_quadrature_decoder_defines.svh @@
`ifndef DEBOUNCED_QUADRATURE_DECODER_DEFINES_SVH
`define DEBOUNCED_QUADRATURE_DECODER_DEFINES_SVH

// Assertion helpers for the decoder.
// Same-cycle implication, checked while reset is released.
`define DQD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while reset is released.
`define DQD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/dqd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dqd_pkg;

    localparam int ENC_IDX_W        = 3;
    localparam int TIME_W           = 32;
    localparam int POS_W            = 32;
    localparam int DEB_W            = 20;
    localparam int MASK_W           = 16;
    localparam int ACC_W            = 3;
    localparam int ACC_SUM_W        = 4;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 20;
    localparam int NUM_ENCODERS_DEF = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_US = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MASK = 2'd1;

    // A detent is four quarter steps in one direction.
    localparam logic signed [ACC_SUM_W-1:0] DETENT_CW  = 4'sd4;
    localparam logic signed [ACC_SUM_W-1:0] DETENT_CCW = -4'sd4;

    typedef logic [TIME_W-1:0] t_time;

    // One encoder's stored state. The previous debounced pair is not kept:
    // at the start of every poll it always equals the debounced pair.
    typedef struct packed {
        logic [1:0]       raw;     // A in bit 1, B in bit 0, after inversion
        logic [1:0]       deb;
        logic [ACC_W-1:0] acc;     // signed, -3..3
        t_time            time_a;
        t_time            time_b;
        logic [POS_W-1:0] pos;
    } t_entry;

    // Quarter-step delta of the standard quadrature sequence 00,01,11,10.
    function automatic logic signed [1:0] quad_delta(input logic [1:0] prev,
                                                     input logic [1:0] curr);
        logic signed [1:0] d;
        case ({prev, curr}) inside
            4'b0001, 4'b0111, 4'b1110, 4'b1000: d = 2'sd1;
            4'b0100, 4'b1101, 4'b1011, 4'b0010: d = -2'sd1;
            default:                            d = 2'sd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

@@ hdl/debounced_quadrature_decoder.sv @@
// Debounced quadrature decoder for up to NUM_ENCODERS rotary encoders. Each input
// transfer is one poll of one encoder (index, raw A and B levels, microsecond
// timestamp) and yields exactly one output transfer with the encoder's wrapping
// quarter-step position and a clockwise or counterclockwise detent flag. A pin
// change is taken into the debounced level only when at least debounce_us has
// passed since that pin's last taken change; timestamps wrap modulo 2^32. Pin
// polarity is set per encoder by invert_mask (bit 2i for A, bit 2i+1 for B).
// Polls for an index at or above NUM_ENCODERS leave all state alone and report
// position 0 with no detent. The block accepts one poll per cycle while o_stall
// is low; it raises o_stall when a result waits in stage 1 behind a stalled output.
// A poll's result comes from the synchronous state memory read at its transfer,
// followed by one update stage into the output register. Polls to the same
// encoder may follow each other back to back: the update just written is
// forwarded to the next read. There is no clearing pass after reset; per-entry
// valid bits make every encoder read as all zero until it is first written.
// Configuration writes are always ready and should be made while idle.
`timescale 1ns / 1ps
`default_nettype none
`include "debounced_quadrature_decoder_defines.svh"

module debounced_quadrature_decoder #(
    parameter int NUM_ENCODERS = dqd_pkg::NUM_ENCODERS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,

    // Poll input
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire  [dqd_pkg::ENC_IDX_W-1:0]      i_encoder_index,
    input  wire                                i_pin_a_level,
    input  wire                                i_pin_b_level,
    input  wire  [dqd_pkg::TIME_W-1:0]         i_now_us,

    // Result output
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic [dqd_pkg::ENC_IDX_W-1:0]      o_result_index,
    output logic signed [dqd_pkg::POS_W-1:0]   o_position,
    output logic                               o_detent_cw,
    output logic                               o_detent_ccw,

    // Configuration writes
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [dqd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [dqd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [dqd_pkg::DEB_W-1:0]  r_debounce_us;
    logic [dqd_pkg::MASK_W-1:0] r_invert_mask;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_us <= '0;
            r_invert_mask <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                dqd_pkg::CFG_DEBOUNCE_US: r_debounce_us <= i_cfg_data[dqd_pkg::DEB_W-1:0];
                dqd_pkg::CFG_INVERT_MASK: r_invert_mask <= i_cfg_data[dqd_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------
    // Stage 1 holds the poll whose entry was read from memory at its
    // transfer. It updates the entry and moves its result into the output
    // register, which frees the stage for the next poll in the same cycle.
    logic                          r_s1_vld;
    logic [dqd_pkg::ENC_IDX_W-1:0] r_s1_idx;
    logic                          r_s1_a;
    logic                          r_s1_b;
    dqd_pkg::t_time                r_s1_now;
    logic                          r_out_vld;

    logic           in_acc;
    logic           s1_fire;
    logic [AW-1:0]  w_addr;
    logic [AW-1:0]  s1_addr;
    logic           w_in_range;
    logic           s1_in_range;

    assign s1_fire = r_s1_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_s1_vld && !s1_fire;
    assign in_acc  = i_valid && !o_stall;

    assign w_addr      = AW'(i_encoder_index);
    assign s1_addr     = AW'(r_s1_idx);
    assign w_in_range  = (int'(i_encoder_index) < NUM_ENCODERS);
    assign s1_in_range = (int'(r_s1_idx) < NUM_ENCODERS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_fire) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_idx <= i_encoder_index;
            r_s1_a   <= i_pin_a_level;
            r_s1_b   <= i_pin_b_level;
            r_s1_now <= i_now_us;
        end
    end

    // ------------------------------------------------------------------
    // State memory, valid bits and forwarding
    // ------------------------------------------------------------------
    dqd_pkg::t_entry   r_mem [NUM_ENCODERS];
    dqd_pkg::t_entry   r_rd_q;
    dqd_pkg::t_entry   r_fw_entry;
    logic [NUM_ENCODERS-1:0] r_valid;
    logic              r_rd_ok;
    logic              r_hit;
    dqd_pkg::t_entry   n_entry;

    always_ff @(posedge i_clk) begin
        if (s1_fire && s1_in_range) begin
            r_mem[s1_addr] <= n_entry;
        end
        if (in_acc) begin
            r_rd_q <= r_mem[w_addr];
        end
        if (s1_fire) begin
            r_fw_entry <= n_entry;
        end
    end

    // An entry that has never been written reads as its reset value of zero.
    // When the poll in stage 1 writes the entry that a new poll reads in the
    // same cycle, the read returns stale data and the written entry is used.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            if (s1_fire && s1_in_range) begin
                r_valid[s1_addr] <= 1'b1;
            end
            if (in_acc) begin
                r_rd_ok <= w_in_range && r_valid[w_addr];
                r_hit   <= s1_fire && s1_in_range && w_in_range && (s1_addr == w_addr);
            end
        end
    end

    // ------------------------------------------------------------------
    // Entry update
    // ------------------------------------------------------------------
    dqd_pkg::t_entry                     base;
    logic                                inv_a;
    logic                                inv_b;
    logic                                pin_a;
    logic                                pin_b;
    dqd_pkg::t_time                      age_a;
    dqd_pkg::t_time                      age_b;
    dqd_pkg::t_time                      deb_limit;
    logic                                take_a;
    logic                                take_b;
    logic [1:0]                          new_deb;
    logic signed [1:0]                   delta;
    logic signed [dqd_pkg::ACC_SUM_W-1:0] acc_sum;
    logic                                n_cw;
    logic                                n_ccw;

    always_comb begin
        if (r_hit) begin
            base = r_fw_entry;
        end else if (r_rd_ok) begin
            base = r_rd_q;
        end else begin
            base = '0;
        end

        inv_a = r_invert_mask[{r_s1_idx, 1'b0}];
        inv_b = r_invert_mask[{r_s1_idx, 1'b1}];
        pin_a = r_s1_a ^ inv_a;
        pin_b = r_s1_b ^ inv_b;

        // Elapsed times wrap with the timestamp, so plain subtraction works.
        deb_limit = dqd_pkg::t_time'(r_debounce_us);
        age_a     = r_s1_now - base.time_a;
        age_b     = r_s1_now - base.time_b;
        take_a    = (pin_a != base.raw[1]) && (age_a >= deb_limit);
        take_b    = (pin_b != base.raw[0]) && (age_b >= deb_limit);

        new_deb = {take_a ? pin_a : base.deb[1], take_b ? pin_b : base.deb[0]};
        delta   = dqd_pkg::quad_delta(base.deb, new_deb);
        acc_sum = $signed({base.acc[dqd_pkg::ACC_W-1], base.acc})
                + $signed({{(dqd_pkg::ACC_SUM_W-2){delta[1]}}, delta});
        n_cw    = (acc_sum == dqd_pkg::DETENT_CW);
        n_ccw   = (acc_sum == dqd_pkg::DETENT_CCW);

        n_entry.raw    = {pin_a, pin_b};
        n_entry.deb    = new_deb;
        n_entry.acc    = (n_cw || n_ccw) ? '0 : acc_sum[dqd_pkg::ACC_W-1:0];
        n_entry.time_a = take_a ? r_s1_now : base.time_a;
        n_entry.time_b = take_b ? r_s1_now : base.time_b;
        n_entry.pos    = base.pos + {{(dqd_pkg::POS_W-2){delta[1]}}, delta};
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [dqd_pkg::ENC_IDX_W-1:0] r_out_idx;
    logic [dqd_pkg::POS_W-1:0]     r_out_pos;
    logic                          r_out_cw;
    logic                          r_out_ccw;

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_idx <= r_s1_idx;
            r_out_pos <= s1_in_range ? n_entry.pos : '0;
            r_out_cw  <= s1_in_range && n_cw;
            r_out_ccw <= s1_in_range && n_ccw;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_result_index = r_out_idx;
    assign o_position     = $signed(r_out_pos);
    assign o_detent_cw    = r_out_cw;
    assign o_detent_ccw   = r_out_ccw;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `DQD_ASSERT_NOW(a_acc_never_full, i_clk, i_rst_n,
        s1_fire && s1_in_range, n_entry.acc != 3'b100,
        "detent accumulator stored at four steps")
    `DQD_ASSERT_NOW(a_detent_exclusive, i_clk, i_rst_n,
        r_out_vld, !(r_out_cw && r_out_ccw),
        "both detent directions flagged on one result")
    `DQD_ASSERT_NEXT(a_out_of_range_quiet, i_clk, i_rst_n,
        s1_fire && !s1_in_range, r_out_pos == '0 && !r_out_cw && !r_out_ccw,
        "result for an unused encoder index carries state")
    `DQD_ASSERT_NOW(a_detent_moves, i_clk, i_rst_n,
        s1_fire && (n_cw || n_ccw), delta != 2'sd0,
        "detent flagged without a quarter step")

endmodule

`default_nettype wire
